// ===== rtl/ipt_pkg.sv =====
// Shared types, constants and timing tables for the IDE PIO timing programmer.
// No dependencies; every other file in rtl/ imports this package.
package ipt_pkg;

  // Mode and field widths
  localparam int unsigned MODE_W    = 3;
  localparam logic [2:0]  MODE_MAX  = 3'd5;
  localparam int unsigned NS_W      = 16;
  localparam int unsigned CLK_W     = 6;
  localparam int unsigned REV_W     = 2;

  // Serial divider: 16-bit time plus (period - 1) needs one extra bit
  localparam int unsigned DIV_W     = NS_W + 1;
  localparam int unsigned DIV_CNT_W = 5;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_REV     = 2'd1;

  // Reset values
  localparam logic [CLK_W-1:0] CLOCK_PERIOD_RST = 6'd25;
  localparam logic [REV_W-1:0] CHIP_REV_RST     = 2'd1;
  localparam logic [7:0]       SEC_SETUP_RST    = 8'h0c;

  // Address setup codes (bits 7:6)
  localparam logic [7:0] SETUP_2CLK = 8'h40;
  localparam logic [7:0] SETUP_3CLK = 8'h80;
  localparam logic [7:0] SETUP_4CLK = 8'h00;
  localparam logic [7:0] SETUP_5CLK = 8'hc0;

  // Limits of the active/recovery packing
  localparam logic [4:0] RECOVERY_CAP = 5'h11;
  localparam logic [4:0] NIBBLE_MAX   = 5'h0f;

  // Which time the shared divider is working on
  typedef enum logic [1:0] {
    DIV_MC,
    DIV_AV,
    DIV_DS
  } div_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     pack;
    logic     commit;
  } ipt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } ipt_status_t;

  // Address setup time per mode, ns
  function automatic logic [NS_W-1:0] mc_ns(input logic [MODE_W-1:0] mode);
    logic [NS_W-1:0] v;
    case (mode)
      3'd0:    v = 16'd70;
      3'd1:    v = 16'd50;
      3'd2:    v = 16'd30;
      3'd3:    v = 16'd30;
      3'd4:    v = 16'd25;
      default: v = 16'd20;
    endcase
    return v;
  endfunction

  // Address valid time per mode, ns
  function automatic logic [NS_W-1:0] av_ns(input logic [MODE_W-1:0] mode);
    logic [NS_W-1:0] v;
    case (mode)
      3'd0:    v = 16'd165;
      3'd1:    v = 16'd125;
      3'd2:    v = 16'd100;
      3'd3:    v = 16'd80;
      3'd4:    v = 16'd70;
      default: v = 16'd50;
    endcase
    return v;
  endfunction

  // Data setup (full cycle) time per mode, ns
  function automatic logic [NS_W-1:0] ds_ns(input logic [MODE_W-1:0] mode);
    logic [NS_W-1:0] v;
    case (mode)
      3'd0:    v = 16'd600;
      3'd1:    v = 16'd383;
      3'd2:    v = 16'd240;
      3'd3:    v = 16'd180;
      3'd4:    v = 16'd125;
      default: v = 16'd100;
    endcase
    return v;
  endfunction

  // Clocks encoded by a setup code
  function automatic logic [2:0] setup_clocks(input logic [7:0] code);
    logic [2:0] c;
    case (code[7:6])
      2'b01:   c = 3'd2;
      2'b10:   c = 3'd3;
      2'b11:   c = 3'd5;
      default: c = 3'd4;
    endcase
    return c;
  endfunction

  // Larger of each nibble
  function automatic logic [7:0] nibble_max(input logic [7:0] a, input logic [7:0] b);
    logic [3:0] lo;
    logic [3:0] hi;
    lo = (a[3:0] > b[3:0]) ? a[3:0] : b[3:0];
    hi = (a[7:4] > b[7:4]) ? a[7:4] : b[7:4];
    return {hi, lo};
  endfunction

endpackage

// ===== rtl/ipt_ctrl.sv =====
// Sequencing controller for the IDE PIO timing programmer.
// Depends on ipt_pkg; drives the datapath through ipt_cmd_t.
module ipt_ctrl import ipt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ipt_status_t status_i,
  output ipt_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_PACK,
    S_COMMIT
  } state_e;

  state_e   state_q, state_d;
  div_sel_e sel_q, sel_d;

  // Next state: three divisions in turn, then pack and commit
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_START;
          sel_d   = DIV_MC;
        end
      end
      S_START: state_d = S_WAIT;
      S_WAIT: begin
        if (status_i.div_done) begin
          case (sel_q)
            DIV_MC: begin
              sel_d   = DIV_AV;
              state_d = S_START;
            end
            DIV_AV: begin
              sel_d   = DIV_DS;
              state_d = S_START;
            end
            default: state_d = S_PACK;
          endcase
        end
      end
      S_PACK: state_d = S_COMMIT;
      S_COMMIT: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and divider selection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= DIV_MC;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  // Decode commands
  assign in_ready_o        = (state_q == S_IDLE);
  assign cmd_o.load        = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.div_start   = (state_q == S_START);
  assign cmd_o.div_sel     = sel_q;
  assign cmd_o.pack        = (state_q == S_PACK);
  assign cmd_o.commit      = (state_q == S_COMMIT) && status_i.out_free;

endmodule

// ===== rtl/ipt_dpath.sv =====
// Datapath: mode selection, shared serial ceiling divider, packing,
// timing register file and result register. Depends on ipt_pkg.
module ipt_dpath import ipt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipt_cmd_t          cmd_i,
  output ipt_status_t       status_o,
  input  logic [CLK_W-1:0]  clock_period_i,
  input  logic [REV_W-1:0]  chip_revision_i,
  input  logic              iface_sel_i,
  input  logic              drive_sel_i,
  input  logic              forced_valid_i,
  input  logic [2:0]        forced_pio_i,
  input  logic [7:0]        reported_pio_i,
  input  logic              eide_valid_i,
  input  logic              iordy_capable_i,
  input  logic [2:0]        eide_mode_bits_i,
  input  logic [NS_W-1:0]   iordy_cycle_ns_i,
  input  logic [NS_W-1:0]   plain_cycle_ns_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [MODE_W-1:0] chosen_pio_o,
  output logic [7:0]        setup_code_o,
  output logic [7:0]        active_recovery_word_o,
  output logic [7:0]        setup_reg_value_o,
  output logic [7:0]        cycle_reg_value_o,
  output logic [7:0]        command_timing_value_o
);

  // ---------------- mode selection ----------------
  logic [MODE_W-1:0] mode_sel;
  logic [NS_W-1:0]   ds_sel;

  always_comb begin
    if (forced_valid_i) begin
      mode_sel = (forced_pio_i > MODE_MAX) ? MODE_MAX : forced_pio_i;
      ds_sel   = ds_ns(mode_sel);
    end else begin
      mode_sel = (reported_pio_i > {5'd0, MODE_MAX}) ? MODE_MAX : reported_pio_i[2:0];
      ds_sel   = ds_ns(mode_sel);
      if (eide_valid_i) begin
        if (iordy_capable_i && (eide_mode_bits_i != 3'd0)) begin
          mode_sel = eide_mode_bits_i[2] ? 3'd5 : (eide_mode_bits_i[1] ? 3'd4 : 3'd3);
          ds_sel   = iordy_cycle_ns_i;
        end else begin
          ds_sel   = plain_cycle_ns_i;
        end
        if (ds_sel == '0) ds_sel = ds_ns(mode_sel);
      end
    end
  end

  // Latch the item's mode, times and target
  logic [MODE_W-1:0] mode_q;
  logic [6:0]        mc_q;
  logic [7:0]        av_q;
  logic [NS_W-1:0]   ds_q;
  logic              iface_q, drive_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_sel;
      mc_q    <= 7'(mc_ns(mode_sel));
      av_q    <= 8'(av_ns(mode_sel));
      ds_q    <= ds_sel;
      iface_q <= iface_sel_i;
      drive_q <= drive_sel_i;
    end
  end

  // ---------------- serial ceiling divider ----------------
  logic [CLK_W-1:0]     clk_eff;
  logic [NS_W-1:0]      div_op;
  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [CLK_W-1:0]     rem_q, rem_d;
  logic [CLK_W:0]       rem_sh;
  logic                 q_bit;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;

  // A zero period counts as one
  assign clk_eff = (clock_period_i == '0) ? CLK_W'(1) : clock_period_i;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_MC:  div_op = {9'd0, mc_q};
      DIV_AV:  div_op = {8'd0, av_q};
      default: div_op = ds_q;
    endcase
  end

  // One restoring step per cycle while busy, quotient shifted into the dividend
  assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, clk_eff});
  assign rem_d  = q_bit ? CLK_W'(rem_sh - {1'b0, clk_eff}) : rem_sh[CLK_W-1:0];
  assign dvd_d  = {dvd_q[DIV_W-2:0], q_bit};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= {1'b0, div_op} + DIV_W'(clk_eff) - DIV_W'(1);
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.div_start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.div_done = done_q;

  // Capture each quotient
  logic [6:0]       q_mc_q;
  logic [7:0]       q_av_q;
  logic [DIV_W-1:0] q_ds_q;

  always_ff @(posedge clk_i) begin
    if (done_q) begin
      case (cmd_i.div_sel)
        DIV_MC:  q_mc_q <= dvd_q[6:0];
        DIV_AV:  q_av_q <= dvd_q[7:0];
        default: q_ds_q <= dvd_q;
      endcase
    end
  end

  // ---------------- packing ----------------
  logic [7:0]         r1_d, r2_d;
  logic [7:0]         act0;
  logic signed [DIV_W:0] diff;
  logic [4:0]         rec0, rec1, rec2;
  logic [DIV_W-1:0]   act1;
  logic [3:0]         act_nib, rec_nib;

  always_comb begin
    // Address setup code
    if (q_mc_q <= 7'd2)      r1_d = SETUP_2CLK;
    else if (q_mc_q == 7'd3) r1_d = SETUP_3CLK;
    else if (q_mc_q == 7'd4) r1_d = SETUP_4CLK;
    else                     r1_d = SETUP_5CLK;

    // Active time is floored at 2; recovery is the rest of the cycle time
    act0 = (q_av_q < 8'd2) ? 8'd2 : q_av_q;
    diff = $signed({1'b0, q_ds_q}) - $signed({{(DIV_W-7){1'b0}}, act0});
    if (diff < $signed((DIV_W+1)'(2))) begin
      rec0 = 5'd2;
    end else if (diff > $signed({{(DIV_W-4){1'b0}}, RECOVERY_CAP})) begin
      rec0 = 5'd31;
    end else begin
      rec0 = diff[4:0];
    end

    // Long recovery moves the excess into the active time
    if (rec0 > RECOVERY_CAP) begin
      act1 = q_ds_q - DIV_W'(RECOVERY_CAP);
      rec1 = RECOVERY_CAP;
    end else begin
      act1 = {{(DIV_W-8){1'b0}}, act0};
      rec1 = rec0;
    end

    act_nib = (act1 > DIV_W'(NIBBLE_MAX)) ? 4'd0 : act1[3:0];
    rec2    = (chip_revision_i > REV_W'(1)) ? rec1 - 5'd1 : rec1;
    rec_nib = (rec2 > NIBBLE_MAX) ? 4'd0 : rec2[3:0];
    r2_d    = {act_nib, rec_nib};
  end

  logic [7:0] r1_q, r2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pack) begin
      r1_q <= r1_d;
      r2_q <= r2_d;
    end
  end

  // ---------------- timing register file ----------------
  logic [7:0] setup_pm_q, cycle_pm_q, setup_ps_q, cycle_ps_q;
  logic [7:0] setup_sec_q, setup_sec_d, cycle_sec_q, cycle_sec_d;
  logic [7:0] cmd_tim_q, cmd_tim_d;
  logic       sec_seen_q;
  logic [7:0] sreg_d, creg_d;

  always_comb begin
    setup_sec_d = setup_sec_q;
    if (!sec_seen_q || (setup_clocks(setup_sec_q) < setup_clocks(r1_q))) begin
      setup_sec_d = {r1_q[7:6], setup_sec_q[5:0]};
    end
    cycle_sec_d = sec_seen_q ? nibble_max(cycle_sec_q, r2_q) : r2_q;
    cmd_tim_d   = nibble_max(cmd_tim_q, r2_q);
    if (iface_q) begin
      sreg_d = setup_sec_d;
      creg_d = cycle_sec_d;
    end else begin
      sreg_d = r1_q;
      creg_d = r2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_pm_q  <= '0;
      cycle_pm_q  <= '0;
      setup_ps_q  <= '0;
      cycle_ps_q  <= '0;
      setup_sec_q <= SEC_SETUP_RST;
      cycle_sec_q <= '0;
      cmd_tim_q   <= '0;
      sec_seen_q  <= 1'b0;
    end else if (cmd_i.commit) begin
      cmd_tim_q <= cmd_tim_d;
      if (iface_q) begin
        setup_sec_q <= setup_sec_d;
        cycle_sec_q <= cycle_sec_d;
        sec_seen_q  <= 1'b1;
      end else if (drive_q) begin
        setup_ps_q <= r1_q;
        cycle_ps_q <= r2_q;
      end else begin
        setup_pm_q <= r1_q;
        cycle_pm_q <= r2_q;
      end
    end
  end

  // ---------------- result register ----------------
  logic out_valid_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      chosen_pio_o           <= mode_q;
      setup_code_o           <= r1_q;
      active_recovery_word_o <= r2_q;
      setup_reg_value_o      <= sreg_d;
      cycle_reg_value_o      <= creg_d;
      command_timing_value_o <= cmd_tim_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/ide_pio_timing_programmer.sv =====
// Top level of the IDE PIO timing programmer: configuration registers,
// controller and datapath. Depends on ipt_pkg, ipt_ctrl and ipt_dpath.
//
// Takes one drive's identify data per transfer and returns one result: the
// chosen PIO mode, the setup code, the active/recovery word and the timing
// register contents after the write. One item is in flight at a time and
// passes through three ceiling divisions on one shared bit-serial divider
// (each a start state, 17 restoring steps and a done strobe), then a pack
// state and a commit state. The commit waits while an earlier result is
// still held. A new input is taken once the previous result has been
// committed to the output register, even if that result has not yet been
// taken. Configuration writes are always accepted and must only be issued
// while the block is idle.
module ide_pio_timing_programmer import ipt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  iface_sel_i,
  input  logic                  drive_sel_i,
  input  logic                  forced_valid_i,
  input  logic [2:0]            forced_pio_i,
  input  logic [7:0]            reported_pio_i,
  input  logic                  eide_valid_i,
  input  logic                  iordy_capable_i,
  input  logic [2:0]            eide_mode_bits_i,
  input  logic [15:0]           iordy_cycle_ns_i,
  input  logic [15:0]           plain_cycle_ns_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            chosen_pio_o,
  output logic [7:0]            setup_code_o,
  output logic [7:0]            active_recovery_word_o,
  output logic [7:0]            setup_reg_value_o,
  output logic [7:0]            cycle_reg_value_o,
  output logic [7:0]            command_timing_value_o
);

  logic [CLK_W-1:0] clock_period_q;
  logic [REV_W-1:0] chip_revision_q;
  ipt_cmd_t         cmd;
  ipt_status_t      status;

  // Configuration registers; writes to unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_period_q  <= CLOCK_PERIOD_RST;
      chip_revision_q <= CHIP_REV_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CLOCK_PERIOD: clock_period_q  <= cfg_data_i[CLK_W-1:0];
        CFG_CHIP_REV:     chip_revision_q <= cfg_data_i[REV_W-1:0];
        default: ;
      endcase
    end
  end

  ipt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ipt_dpath u_dpath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .status_o               (status),
    .clock_period_i         (clock_period_q),
    .chip_revision_i        (chip_revision_q),
    .iface_sel_i            (iface_sel_i),
    .drive_sel_i            (drive_sel_i),
    .forced_valid_i         (forced_valid_i),
    .forced_pio_i           (forced_pio_i),
    .reported_pio_i         (reported_pio_i),
    .eide_valid_i           (eide_valid_i),
    .iordy_capable_i        (iordy_capable_i),
    .eide_mode_bits_i       (eide_mode_bits_i),
    .iordy_cycle_ns_i       (iordy_cycle_ns_i),
    .plain_cycle_ns_i       (plain_cycle_ns_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .chosen_pio_o           (chosen_pio_o),
    .setup_code_o           (setup_code_o),
    .active_recovery_word_o (active_recovery_word_o),
    .setup_reg_value_o      (setup_reg_value_o),
    .cycle_reg_value_o      (cycle_reg_value_o),
    .command_timing_value_o (command_timing_value_o)
  );

  // Busy straight after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // A result only appears from a running item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised without an item in flight");

  // Chosen mode never exceeds the top PIO mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (chosen_pio_o <= MODE_MAX))
    else $error("chosen PIO mode out of range");

  // Setup code carries clocks in bits 7:6 only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (setup_code_o[5:0] == 6'd0))
    else $error("setup code has stray low bits");

endmodule
